@@ design/mpwm_pkg.sv @@
// Shared constants, codes and types for the multichannel PWM block.
// No dependencies; every other design file imports this package.
package mpwm_pkg;

    localparam int CHANNELS = 8;

    localparam logic [7:0]  CHAN_MASK  = 8'((1 << CHANNELS) - 1);
    localparam logic [13:0] FULL_LEVEL = 14'd10000;

    // Scaled values are duty or counter positions times FULL_LEVEL.
    localparam int SCALED_W = 30;
    localparam logic [SCALED_W-1:0] SCALED_STEP = SCALED_W'(10000);

    // Input function codes.
    localparam logic [1:0] FUNC_PWM_TICK    = 2'd0;
    localparam logic [1:0] FUNC_REPORT_TICK = 2'd1;
    localparam logic [1:0] FUNC_SET_LEVEL   = 2'd2;
    localparam logic [1:0] FUNC_QUERY_LEVEL = 2'd3;

    // Reply kinds.
    localparam logic [1:0] KIND_PINS   = 2'd0;
    localparam logic [1:0] KIND_ECHO   = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;
    localparam logic [1:0] KIND_REPORT = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PERIOD   = 2'd0;
    localparam logic [1:0] CFG_ENABLE   = 2'd1;
    localparam logic [1:0] CFG_INVERT   = 2'd2;
    localparam logic [1:0] CFG_AUTO_OFF = 2'd3;

    // Counter status handed to the channel logic for one PWM tick.
    typedef struct packed {
        logic                wrap;
        logic [SCALED_W-1:0] scaled_next;
    } t_tick_info;

endpackage

@@ design/multichannel_pwm_with_autooff_top.sv @@
// Top level of the multichannel PWM generator with auto-off.
// Depends on mpwm_pkg, mpwm_duty_calc and mpwm_counter.
//
// This block drives up to eight PWM pins from one shared period counter and
// answers set, query and report commands with exactly one result per
// command. A command is held in the input register and is then written to
// the result register, from which its result is offered and transferred out.
// A new command is accepted every cycle while the result side keeps
// draining, so the sustained rate is one command per clock; when the result
// side stalls, the input register and the result register hold one command
// each before the command channel is stalled. The rate is set by the
// combinational channel update: the duty multiplier, the eight parallel duty
// compares and the round-robin search all complete between the input
// register and the result register. Duties are held as level * period
// (undivided; full scale as (period + 1) * 10000), and the counter keeps
// (count + 1) * 10000, so no divider is needed. Configuration is written
// through its own port, which is always ready, and should only change while
// no command is in flight.
module multichannel_pwm_with_autooff_top
    import mpwm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Command channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_chan,
    input  logic [15:0] i_level_in,

    // Result channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_pin_levels,
    output logic [1:0]  o_reply_kind,
    output logic [2:0]  o_reply_chan,
    output logic [13:0] o_reply_level,
    output logic        o_error,

    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // Configuration registers.
    logic [15:0] r_period;
    logic [7:0]  r_enable;
    logic [7:0]  r_invert;
    logic [7:0]  r_auto_off;

    // Input register.
    logic        r_s1_valid;
    logic [1:0]  r_s1_func;
    logic [7:0]  r_s1_chan;
    logic [15:0] r_s1_level;

    // Channel state.
    logic [SCALED_W-1:0] r_duty   [CHANNELS];
    logic [13:0]         r_level  [CHANNELS];
    logic [7:0]          r_cntdn  [CHANNELS];
    logic [SCALED_W-1:0] n_duty   [CHANNELS];
    logic [13:0]         n_level  [CHANNELS];
    logic [7:0]          n_cntdn  [CHANNELS];
    logic [7:0]          r_active;
    logic [7:0]          n_active;
    logic [2:0]          r_ptr;
    logic [2:0]          n_ptr;

    // Result register.
    logic        r_out_valid;
    logic [7:0]  r_pins;
    logic [1:0]  r_kind;
    logic [2:0]  r_rchan;
    logic [13:0] r_rlevel;
    logic        r_err;
    logic [1:0]  n_kind;
    logic [2:0]  n_rchan;
    logic [13:0] n_rlevel;
    logic        n_err;

    logic                advance;
    logic                in_accept;
    logic [7:0]          en;
    logic [13:0]         level_sat;
    logic [SCALED_W-1:0] scaled_duty;
    t_tick_info          tick_info;
    logic [2:0]          ptr_start;
    logic [2:0]          pick;
    logic [3:0]          cand;
    logic [3:0]          pick_inc;
    logic [7:0]          cnt_dec;
    logic [2:0]          sel;

    // The command in the input register moves on when the result register
    // is empty or its result is being transferred out in this cycle.
    assign advance   = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_s1_valid && !advance;
    assign in_accept = i_valid && !o_stall;
    assign en        = r_enable & CHAN_MASK;
    assign sel       = r_s1_chan[2:0];

    mpwm_duty_calc u_duty (
        .i_level_in    (r_s1_level),
        .i_period      (r_period),
        .o_level_sat   (level_sat),
        .o_scaled_duty (scaled_duty)
    );

    mpwm_counter u_counter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (advance && (r_s1_func == FUNC_PWM_TICK)),
        .i_period (r_period),
        .o_info   (tick_info)
    );

    // Round-robin search: the first enabled channel at or after the pointer.
    // Walking the offsets downward lets the smallest offset win.
    always_comb begin
        ptr_start = (32'(r_ptr) >= CHANNELS) ? 3'd0 : r_ptr;
        pick      = ptr_start;
        for (int n = CHANNELS - 1; n >= 0; n--) begin
            cand = {1'b0, ptr_start} + 4'(n);
            if (32'(cand) >= CHANNELS) begin
                cand = cand - 4'(CHANNELS);
            end
            if (en[cand[2:0]]) begin
                pick = cand[2:0];
            end
        end
        pick_inc = {1'b0, pick} + 4'd1;
    end

    // Channel update and result for the command in the input register.
    always_comb begin
        n_duty   = r_duty;
        n_level  = r_level;
        n_cntdn  = r_cntdn;
        n_active = r_active;
        n_ptr    = r_ptr;
        n_kind   = KIND_PINS;
        n_rchan  = 3'd0;
        n_rlevel = 14'd0;
        n_err    = 1'b0;
        cnt_dec  = r_cntdn[pick] - 8'd1;

        unique case (r_s1_func)
            FUNC_PWM_TICK: begin
                // On a wrap enabled channels with duty >= SCALED_STEP turn on;
                // then any enabled channel at or past its duty turns off.
                for (int i = 0; i < CHANNELS; i++) begin
                    if (en[i] && tick_info.wrap && (r_duty[i] >= SCALED_STEP)) begin
                        n_active[i] = 1'b1;
                    end
                    if (en[i] && (tick_info.scaled_next > r_duty[i])) begin
                        n_active[i] = 1'b0;
                    end
                end
            end
            FUNC_REPORT_TICK: begin
                if (en == 8'd0) begin
                    n_err = 1'b1;
                end else begin
                    n_kind   = KIND_REPORT;
                    n_rchan  = pick;
                    n_rlevel = r_level[pick];
                    if (r_auto_off != 8'd0) begin
                        n_cntdn[pick] = cnt_dec;
                        if (cnt_dec == 8'd0) begin
                            n_duty[pick]  = '0;
                            n_level[pick] = 14'd0;
                            n_cntdn[pick] = 8'd1;
                        end
                    end
                    n_ptr = (32'(pick_inc) >= CHANNELS) ? 3'd0 : pick_inc[2:0];
                end
            end
            FUNC_SET_LEVEL: begin
                if (32'(r_s1_chan) >= CHANNELS) begin
                    n_err = 1'b1;
                end else begin
                    n_level[sel] = level_sat;
                    n_duty[sel]  = scaled_duty;
                    n_cntdn[sel] = r_auto_off;
                    n_kind       = KIND_ECHO;
                    n_rchan      = sel;
                    n_rlevel     = level_sat;
                end
            end
            FUNC_QUERY_LEVEL: begin
                if (32'(r_s1_chan) >= CHANNELS) begin
                    n_err = 1'b1;
                end else begin
                    n_kind   = KIND_QUERY;
                    n_rchan  = sel;
                    n_rlevel = r_level[sel];
                end
            end
            default: begin
                n_err = 1'b0;
            end
        endcase
    end

    // Configuration writes.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= 16'd10;
            r_enable   <= 8'hFF;
            r_invert   <= 8'h00;
            r_auto_off <= 8'h00;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PERIOD:   r_period   <= i_cfg_data;
                CFG_ENABLE:   r_enable   <= i_cfg_data[7:0];
                CFG_INVERT:   r_invert   <= i_cfg_data[7:0];
                CFG_AUTO_OFF: r_auto_off <= i_cfg_data[7:0];
                default:      r_period   <= r_period;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_func  <= i_func;
            r_s1_chan  <= i_chan;
            r_s1_level <= i_level_in;
        end
    end

    // Channel state; all channels start active, with zero duty and level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_duty[i]  <= '0;
                r_level[i] <= 14'd0;
                r_cntdn[i] <= 8'd0;
            end
            r_active <= CHAN_MASK;
            r_ptr    <= 3'd0;
        end else if (advance) begin
            r_duty   <= n_duty;
            r_level  <= n_level;
            r_cntdn  <= n_cntdn;
            r_active <= n_active;
            r_ptr    <= n_ptr;
        end
    end

    // Result register; the pins are sampled after the command's update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_pins   <= (n_active ^ r_invert) & en;
            r_kind   <= n_kind;
            r_rchan  <= n_rchan;
            r_rlevel <= n_rlevel;
            r_err    <= n_err;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pin_levels  = r_pins;
    assign o_reply_kind  = r_kind;
    assign o_reply_chan  = r_rchan;
    assign o_reply_level = r_rlevel;
    assign o_error       = r_err;

endmodule

@@ design/mpwm_duty_calc.sv @@
// Duty product for a set command: saturates the level and forms the scaled duty.
// Depends on mpwm_pkg.
module mpwm_duty_calc
    import mpwm_pkg::*;
(
    input  logic [15:0]         i_level_in,
    input  logic [15:0]         i_period,
    output logic [13:0]         o_level_sat,
    output logic [SCALED_W-1:0] o_scaled_duty
);

    logic                full;
    logic [13:0]         op_a;
    logic [16:0]         op_b;
    logic [SCALED_W-1:0] product;

    // Full scale stores (period + 1) * 10000, so the counter never passes it.
    // Otherwise the product level * period is kept undivided; the channel
    // compare works in the same scaled units.
    always_comb begin
        full        = (i_level_in >= 16'(FULL_LEVEL));
        o_level_sat = full ? FULL_LEVEL : i_level_in[13:0];
        op_a        = full ? FULL_LEVEL : i_level_in[13:0];
        op_b        = full ? ({1'b0, i_period} + 17'd1) : {1'b0, i_period};
        product     = SCALED_W'(op_a) * SCALED_W'(op_b);
    end

    assign o_scaled_duty = product;

endmodule

@@ design/mpwm_counter.sv @@
// Shared PWM period counter with a running copy of (count + 1) * 10000.
// Depends on mpwm_pkg.
module mpwm_counter
    import mpwm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tick,
    input  logic [15:0] i_period,
    output t_tick_info  o_info
);

    logic [15:0]         r_count;
    logic [SCALED_W-1:0] r_scaled;
    logic [16:0]         count_inc;
    logic [15:0]         n_count;
    logic [SCALED_W-1:0] n_scaled;

    always_comb begin
        count_inc          = {1'b0, r_count} + 17'd1;
        o_info.wrap        = (count_inc >= {1'b0, i_period});
        n_count            = o_info.wrap ? 16'd0 : count_inc[15:0];
        n_scaled           = o_info.wrap ? SCALED_STEP : (r_scaled + SCALED_STEP);
        o_info.scaled_next = n_scaled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_scaled <= SCALED_STEP;
        end else if (i_tick) begin
            r_count  <= n_count;
            r_scaled <= n_scaled;
        end
    end

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the eight-channel PWM generator with auto-off.
// Depends on mpwm_pkg, multichannel_pwm_with_autooff_top and the latter's submodules.
module tb
    import mpwm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // One result transfer, field by field, as the block presents it.
    typedef struct packed {
        logic [7:0]  pins;
        logic [1:0]  kind;
        logic [2:0]  chan;
        logic [13:0] level;
        logic        err;
    } t_reply;

    // One row of the directed table. A row is either a command or a register
    // write; for commands whose reply is obvious, the reply is typed in.
    typedef struct packed {
        logic        cfg;
        logic [1:0]  code;
        logic [7:0]  chan;
        logic [15:0] data;
        logic        typed;
        t_reply      want;
    } t_stim_row;

    localparam t_reply NO_REPLY = '0;

    localparam int DIR_N           = 33;
    localparam int N_PHASES        = 10;
    localparam int ITEMS_PER_PHASE = 48;
    localparam int HOLD_CYCLES     = 60;
    localparam int DRAIN_CYCLES    = 4;
    localparam int CYCLE_LIMIT     = 200000;

    // Directed part. It starts from the reset state: period 10, all channels
    // enabled and active, no inversion, auto-off disabled.
    localparam t_stim_row DIR_ROWS [DIR_N] = '{
        // Query right after reset: all pins high, level zero.
        '{1'b0, FUNC_QUERY_LEVEL, 8'd0, 16'd0, 1'b1, '{8'hFF, KIND_QUERY, 3'd0, 14'd0, 1'b0}},
        // Set on a channel that does not exist.
        '{1'b0, FUNC_SET_LEVEL, 8'd8, 16'd5000, 1'b1, '{8'hFF, KIND_PINS, 3'd0, 14'd0, 1'b1}},
        // Saturation: any level from full scale upward is stored as full scale.
        '{1'b0, FUNC_SET_LEVEL, 8'd7, 16'hFFFF, 1'b1, '{8'hFF, KIND_ECHO, 3'd7, 14'd10000, 1'b0}},
        '{1'b0, FUNC_SET_LEVEL, 8'd0, 16'd10000, 1'b1, '{8'hFF, KIND_ECHO, 3'd0, 14'd10000, 1'b0}},
        '{1'b0, FUNC_SET_LEVEL, 8'd1, 16'd9999, 1'b1, '{8'hFF, KIND_ECHO, 3'd1, 14'd9999, 1'b0}},
        '{1'b0, FUNC_SET_LEVEL, 8'd2, 16'd0, 1'b1, '{8'hFF, KIND_ECHO, 3'd2, 14'd0, 1'b0}},
        '{1'b0, FUNC_REPORT_TICK, 8'd0, 16'd0, 1'b1, '{8'hFF, KIND_REPORT, 3'd0, 14'd10000, 1'b0}},
        '{1'b0, FUNC_SET_LEVEL, 8'd3, 16'd5000, 1'b0, NO_REPLY},
        // Eight ticks: channels drop out as the counter passes their duty.
        '{1'b0, FUNC_PWM_TICK, 8'd0, 16'd0, 1'b0, NO_REPLY},
        '{1'b0, FUNC_PWM_TICK, 8'd0, 16'd0, 1'b0, NO_REPLY},
        '{1'b0, FUNC_PWM_TICK, 8'd0, 16'd0, 1'b0, NO_REPLY},
        '{1'b0, FUNC_PWM_TICK, 8'd0, 16'd0, 1'b0, NO_REPLY},
        '{1'b0, FUNC_PWM_TICK, 8'd0, 16'd0, 1'b0, NO_REPLY},
        '{1'b0, FUNC_PWM_TICK, 8'd0, 16'd0, 1'b0, NO_REPLY},
        '{1'b0, FUNC_PWM_TICK, 8'd0, 16'd0, 1'b0, NO_REPLY},
        '{1'b0, FUNC_PWM_TICK, 8'd0, 16'd0, 1'b0, NO_REPLY},
        '{1'b0, FUNC_REPORT_TICK, 8'd0, 16'd0, 1'b0, NO_REPLY},
        // Auto-off: a reload of two clears the channel on its second report.
        '{1'b1, CFG_AUTO_OFF, 8'd0, 16'd2, 1'b0, NO_REPLY},
        '{1'b0, FUNC_SET_LEVEL, 8'd5, 16'd3000, 1'b0, NO_REPLY},
        '{1'b1, CFG_ENABLE, 8'd0, 16'h0020, 1'b0, NO_REPLY},
        '{1'b0, FUNC_REPORT_TICK, 8'd0, 16'd0, 1'b0, NO_REPLY},
        '{1'b0, FUNC_REPORT_TICK, 8'd0, 16'd0, 1'b0, NO_REPLY},
        '{1'b0, FUNC_QUERY_LEVEL, 8'd5, 16'd0, 1'b0, NO_REPLY},
        // Report with no channel enabled: error, all pins low.
        '{1'b1, CFG_ENABLE, 8'd0, 16'h0000, 1'b0, NO_REPLY},
        '{1'b0, FUNC_REPORT_TICK, 8'd0, 16'd0, 1'b1, '{8'h00, KIND_PINS, 3'd0, 14'd0, 1'b1}},
        // Period lowered below the running counter: the next tick wraps.
        '{1'b1, CFG_ENABLE, 8'd0, 16'h00FF, 1'b0, NO_REPLY},
        '{1'b1, CFG_INVERT, 8'd0, 16'h00A5, 1'b0, NO_REPLY},
        '{1'b1, CFG_PERIOD, 8'd0, 16'd4, 1'b0, NO_REPLY},
        '{1'b0, FUNC_PWM_TICK, 8'd0, 16'd0, 1'b0, NO_REPLY},
        '{1'b1, CFG_PERIOD, 8'd0, 16'd0, 1'b0, NO_REPLY},
        '{1'b0, FUNC_PWM_TICK, 8'd0, 16'd0, 1'b0, NO_REPLY},
        // Largest period with the largest unsaturated level.
        '{1'b1, CFG_PERIOD, 8'd0, 16'hFFFF, 1'b0, NO_REPLY},
        '{1'b0, FUNC_SET_LEVEL, 8'd4, 16'd9999, 1'b0, NO_REPLY}
    };

    // Block ports.
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_stall;
    logic [1:0]  i_func        = FUNC_PWM_TICK;
    logic [7:0]  i_chan        = 8'd0;
    logic [15:0] i_level_in    = 16'd0;
    logic        o_valid;
    logic        i_stall       = 1'b0;
    logic [7:0]  o_pin_levels;
    logic [1:0]  o_reply_kind;
    logic [2:0]  o_reply_chan;
    logic [13:0] o_reply_level;
    logic        o_error;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index   = CFG_PERIOD;
    logic [15:0] i_cfg_data    = 16'd0;

    // Shadow copy of the block's registers and state, kept by the predictor.
    logic [15:0] m_period;
    logic [7:0]  m_enable;
    logic [7:0]  m_invert;
    logic [7:0]  m_reload;
    logic [15:0] m_count;
    logic [16:0] m_duty [CHANNELS];
    logic [13:0] m_level [CHANNELS];
    logic [7:0]  m_countdown [CHANNELS];
    logic [2:0]  m_rptr;
    logic [7:0]  m_active;

    // Replies still owed by the block, oldest first.
    t_reply reply_q [$];

    // Idling controls. The long output hold is requested by bumping
    // hold_req; the stall process counts the hold itself.
    bit tx_bursts = 1'b1;
    bit rx_bursts = 1'b1;
    int hold_req  = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_left = 0;

    int cycle_cnt = 0;
    int n_fail    = 0;
    int n_sent    = 0;
    int n_checked = 0;
    int n_reports = 0;
    int n_errors  = 0;
    int n_cfg     = 0;

    multichannel_pwm_with_autooff_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_chan        (i_chan),
        .i_level_in    (i_level_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pin_levels  (o_pin_levels),
        .o_reply_kind  (o_reply_kind),
        .o_reply_chan  (o_reply_chan),
        .o_reply_level (o_reply_level),
        .o_error       (o_error),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Computes the reply to one accepted command and advances the shadow
    // state. Every command yields exactly one reply.
    function automatic t_reply next_reply(input logic [1:0] func, input logic [7:0] chan,
                                          input logic [15:0] lvl);
        t_reply      r;
        logic [7:0]  en;
        logic [16:0] nxt;
        logic [2:0]  p;
        logic [31:0] prod;
        int          i;
        int          n;
        r  = '0;
        en = m_enable & CHAN_MASK;
        case (func)
            FUNC_PWM_TICK: begin
                // On a wrap, every enabled channel with a nonzero duty turns on;
                // then any enabled channel at or past its duty turns off.
                nxt = {1'b0, m_count} + 17'd1;
                if (nxt >= {1'b0, m_period}) begin
                    nxt = '0;
                    for (i = 0; i < CHANNELS; i++)
                        if (en[i] && m_duty[i] != 0) m_active[i] = 1'b1;
                end
                m_count = nxt[15:0];
                for (i = 0; i < CHANNELS; i++)
                    if (en[i] && {1'b0, m_count} >= m_duty[i]) m_active[i] = 1'b0;
            end
            FUNC_REPORT_TICK: begin
                if (en == 0) begin
                    r.err = 1'b1;
                end else begin
                    p = m_rptr;
                    if (p >= CHANNELS) p = 0;
                    for (n = 0; n < CHANNELS && !en[p]; n++)
                        p = (p + 1 >= CHANNELS) ? 3'd0 : p + 3'd1;
                    r.kind  = KIND_REPORT;
                    r.chan  = p;
                    r.level = m_level[p];
                    // The countdown wraps from zero; reaching zero clears the
                    // channel, but the report still carries the old level.
                    if (m_reload != 0) begin
                        m_countdown[p] = m_countdown[p] - 8'd1;
                        if (m_countdown[p] == 0) begin
                            m_duty[p]      = '0;
                            m_level[p]     = '0;
                            m_countdown[p] = 8'd1;
                        end
                    end
                    m_rptr = (p + 1 >= CHANNELS) ? 3'd0 : p + 3'd1;
                end
            end
            default: begin
                if (chan >= CHANNELS) begin
                    r.err = 1'b1;
                end else if (func == FUNC_SET_LEVEL) begin
                    if (lvl >= FULL_LEVEL) begin
                        m_level[chan[2:0]] = FULL_LEVEL;
                        m_duty[chan[2:0]]  = {1'b0, m_period} + 17'd1;
                    end else begin
                        m_level[chan[2:0]] = lvl[13:0];
                        prod = 32'(lvl) * 32'(m_period);
                        m_duty[chan[2:0]] = 17'(prod / 32'(FULL_LEVEL));
                    end
                    m_countdown[chan[2:0]] = m_reload;
                    r.kind  = KIND_ECHO;
                    r.chan  = chan[2:0];
                    r.level = m_level[chan[2:0]];
                end else begin
                    r.kind  = KIND_QUERY;
                    r.chan  = chan[2:0];
                    r.level = m_level[chan[2:0]];
                end
            end
        endcase
        r.pins = (m_active ^ m_invert) & en;
        return r;
    endfunction

    // Offers one command and holds it until the block takes it. The reply is
    // predicted at the transfer; a typed-in reply replaces the prediction.
    task automatic send_cmd(input logic [1:0] func, input logic [7:0] chan,
                            input logic [15:0] lvl, input logic typed, input t_reply want);
        t_reply r;
        @(negedge i_clk);
        i_valid    <= 1'b1;
        i_func     <= func;
        i_chan     <= chan;
        i_level_in <= lvl;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        r = next_reply(func, chan, lvl);
        reply_q.push_back(typed ? want : r);
        n_sent++;
    endtask

    // Occasionally leaves the command channel idle for a burst of cycles.
    task automatic sender_gap();
        int g;
        if (tx_bursts && $urandom_range(0, 5) == 0) begin
            g = $urandom_range(1, 14);
            repeat (g) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
        end
    endtask

    // Waits until every owed reply has arrived and the pipeline is empty.
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_PERIOD: m_period = val;
            CFG_ENABLE: m_enable = val[7:0];
            CFG_INVERT: m_invert = val[7:0];
            default:    m_reload = val[7:0];
        endcase
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Result side: random stall bursts, plus one long hold on request so the
    // block fills up and pushes back on the command channel.
    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES - 1;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (rx_bursts && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 13);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Every result transfer is matched against the oldest owed reply.
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (reply_q.size() == 0) begin
                $error("result transfer with no reply pending");
                n_fail++;
            end else begin
                want = reply_q.pop_front();
                n_checked++;
                if (want.kind == KIND_REPORT) n_reports++;
                if (want.err) n_errors++;
                if (o_pin_levels !== want.pins) begin
                    $error("pin_levels: expected %0h, got %0h", want.pins, o_pin_levels);
                    n_fail++;
                end
                if (o_reply_kind !== want.kind) begin
                    $error("reply_kind: expected %0d, got %0d", want.kind, o_reply_kind);
                    n_fail++;
                end
                if (o_reply_chan !== want.chan) begin
                    $error("reply_chan: expected %0d, got %0d", want.chan, o_reply_chan);
                    n_fail++;
                end
                if (o_reply_level !== want.level) begin
                    $error("reply_level: expected %0d, got %0d", want.level, o_reply_level);
                    n_fail++;
                end
                if (o_error !== want.err) begin
                    $error("error: expected %0d, got %0d", want.err, o_error);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog: the slowest correct run stays far below this many cycles.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        int          k;
        int          ph;
        int          sel;
        logic [1:0]  f;
        logic [7:0]  c;
        logic [15:0] lv;
        logic [15:0] per;
        logic [7:0]  en;
        logic [7:0]  inv;
        logic [7:0]  ao;

        // Shadow state matches the block right after reset.
        m_period = 16'd10;
        m_enable = 8'hFF;
        m_invert = 8'h00;
        m_reload = 8'h00;
        m_count  = '0;
        m_rptr   = '0;
        for (k = 0; k < CHANNELS; k++) begin
            m_duty[k]      = '0;
            m_level[k]     = '0;
            m_countdown[k] = '0;
        end
        m_active = m_enable & CHAN_MASK;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Register writes only happen once the block is idle.
        for (k = 0; k < DIR_N; k++) begin
            if (DIR_ROWS[k].cfg) begin
                drain();
                cfg_write(DIR_ROWS[k].code, DIR_ROWS[k].data);
            end else begin
                send_cmd(DIR_ROWS[k].code, DIR_ROWS[k].chan, DIR_ROWS[k].data,
                         DIR_ROWS[k].typed, DIR_ROWS[k].want);
                sender_gap();
            end
        end

        // Random phases, each under its own register setting. The first two
        // phases take the extremes; the rest mostly use short periods and
        // short auto-off reloads so wraps and clears happen often.
        for (ph = 0; ph < N_PHASES; ph++) begin
            if (ph == 0) begin
                per = 16'hFFFF;
                en  = 8'hFF;
                inv = 8'hFF;
                ao  = 8'hFF;
            end else if (ph == 1) begin
                per = 16'd0;
                en  = 8'h00;
                inv = 8'h00;
                ao  = 8'h00;
            end else begin
                sel = $urandom_range(0, 9);
                per = (sel == 0) ? 16'd0 : (sel == 1) ? 16'hFFFF : (sel == 2) ? 16'd1 :
                      16'($urandom_range(2, 30));
                sel = $urandom_range(0, 7);
                en  = (sel < 2) ? 8'hFF : 8'($urandom_range(1, 255));
                inv = 8'($urandom);
                sel = $urandom_range(0, 5);
                ao  = (sel == 0) ? 8'd0 : (sel == 1) ? 8'hFF : 8'($urandom_range(1, 4));
            end
            drain();
            cfg_write(CFG_PERIOD, per);
            cfg_write(CFG_ENABLE, {8'd0, en});
            cfg_write(CFG_INVERT, {8'd0, inv});
            cfg_write(CFG_AUTO_OFF, {8'd0, ao});

            // The last two phases run at full rate on both sides. Phase two
            // keeps the command side busy while the result side holds off.
            tx_bursts = (ph < N_PHASES - 2) && (ph != 2);
            rx_bursts = (ph < N_PHASES - 2);
            if (ph == 2) hold_req++;

            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                // Midway through phase five the sender waits for every reply.
                if (ph == 5 && k == ITEMS_PER_PHASE / 2) drain();
                sel = $urandom_range(0, 99);
                f = (sel < 40) ? FUNC_PWM_TICK : (sel < 58) ? FUNC_REPORT_TICK :
                    (sel < 83) ? FUNC_SET_LEVEL : FUNC_QUERY_LEVEL;
                sel = $urandom_range(0, 15);
                c = (sel == 0) ? 8'hFF : (sel == 1) ? 8'($urandom_range(8, 255)) :
                    8'($urandom_range(0, CHANNELS - 1));
                sel = $urandom_range(0, 7);
                lv = (sel == 0) ? 16'd0 : (sel == 1) ? 16'(FULL_LEVEL) :
                     (sel == 2) ? 16'($urandom_range(10000, 65535)) :
                     16'($urandom_range(0, 9999));
                send_cmd(f, c, lv, 1'b0, NO_REPLY);
                sender_gap();
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d commands sent, %0d replies checked, %0d reports, %0d error replies",
                 n_sent, n_checked, n_reports, n_errors);
        $display("summary: %0d register writes over %0d settings, with a long output hold",
                 n_cfg, N_PHASES + 3);
        if (n_fail == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/mpwm_pkg.sv
design/mpwm_duty_calc.sv
design/mpwm_counter.sv
design/multichannel_pwm_with_autooff_top.sv
bench/tb.sv
